// File: rtl/core/blt_pkg.sv
// shared types and constants for the bounded keyed lifo table
`default_nettype none

package blt_pkg;

  // table depth and derived widths
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int LIM_W    = 5;
  localparam int CMP_W    = (CNT_W > LIM_W) ? CNT_W : LIM_W;

  // operation codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  // register byte addresses
  localparam logic [1:0] ADDR_MAX_ENTRIES = 2'd0;
  localparam logic [LIM_W-1:0] MAX_ENTRIES_RESET = LIM_W'(16);

  // one stored pair
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] value;
  } entry_t;

  // memory access from the sequencer
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// File: rtl/core/blt_ram.sv
// generic single-write single-read ram with registered read data
`default_nettype none

module blt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                                          clk,
  input  wire logic                                          we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]                              wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic      [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/blt_ctrl.sv
// sequencer: add at the top, scan newest first, close gaps on remove
`default_nettype none

module blt_ctrl
  import blt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [1:0]        operation,
  input  wire logic [31:0]       key,
  input  wire logic [31:0]       value_in,
  input  wire logic [LIM_W-1:0]  max_entries,
  output logic                   busy,
  output logic                   done,
  output logic      [1:0]        status,
  output logic      [31:0]       value_out,
  output logic      [4:0]        entry_count,
  output mem_req_t               mem_req,
  input  wire entry_t            rdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] idx;
  logic [31:0]      key_q;
  logic [31:0]      hit_value;
  logic             remove_q;

  logic [CNT_W-1:0] last_idx;
  logic             idx_is_last;
  logic             hit;
  logic             room;

  // entries live at addresses 0..count-1, newest at the top
  assign last_idx    = count - CNT_W'(1);
  assign idx_is_last = (CNT_W'(idx) == last_idx);
  assign hit         = (rdata.key == key_q);
  assign room        = (CMP_W'(count) < CMP_W'(max_entries)) && (count < CNT_W'(CAPACITY));
  assign busy        = (state != S_IDLE);

  // memory read address and write port
  always_comb begin
    case (state)
      S_IDLE:  mem_req.raddr = IDX_W'(last_idx);
      S_SCAN:  mem_req.raddr = hit ? (idx + IDX_W'(1)) : (idx - IDX_W'(1));
      S_SHIFT: mem_req.raddr = idx + IDX_W'(1);
      default: mem_req.raddr = idx;
    endcase
    if (state == S_SHIFT) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = idx - IDX_W'(1);
      mem_req.wdata = rdata;
    end else begin
      mem_req.we    = (state == S_IDLE) && start && (operation == OP_ADD) && room;
      mem_req.waddr = IDX_W'(count);
      mem_req.wdata = '{key: key, value: value_in};
    end
  end

  // state, count and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            case (operation)
              OP_ADD: begin
                done <= 1'b1;
                if (room) begin
                  count       <= count + CNT_W'(1);
                  status      <= ST_DONE;
                  value_out   <= value_in;
                  entry_count <= 5'(count + CNT_W'(1));
                end else begin
                  status      <= ST_FULL;
                  value_out   <= '0;
                  entry_count <= 5'(count);
                end
              end
              OP_CLEAR: begin
                count       <= '0;
                done        <= 1'b1;
                status      <= ST_DONE;
                value_out   <= '0;
                entry_count <= '0;
              end
              default: begin
                key_q    <= key;
                remove_q <= (operation == OP_REMOVE);
                if (count == '0) begin
                  done        <= 1'b1;
                  status      <= ST_MISS;
                  value_out   <= '0;
                  entry_count <= '0;
                end else begin
                  idx   <= IDX_W'(last_idx);
                  state <= S_SCAN;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            if (!remove_q) begin
              done        <= 1'b1;
              status      <= ST_DONE;
              value_out   <= rdata.value;
              entry_count <= 5'(count);
              state       <= S_IDLE;
            end else if (idx_is_last) begin
              // newest entry removed, nothing to move
              count       <= last_idx;
              done        <= 1'b1;
              status      <= ST_DONE;
              value_out   <= rdata.value;
              entry_count <= 5'(last_idx);
              state       <= S_IDLE;
            end else begin
              hit_value <= rdata.value;
              idx       <= idx + IDX_W'(1);
              state     <= S_SHIFT;
            end
          end else if (idx == '0) begin
            done        <= 1'b1;
            status      <= ST_MISS;
            value_out   <= '0;
            entry_count <= 5'(count);
            state       <= S_IDLE;
          end else begin
            idx <= idx - IDX_W'(1);
          end
        end
        S_SHIFT: begin
          // each cycle moves one newer entry down over the gap
          if (idx_is_last) begin
            count       <= last_idx;
            done        <= 1'b1;
            status      <= ST_DONE;
            value_out   <= hit_value;
            entry_count <= 5'(last_idx);
            state       <= S_IDLE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/bounded_keyed_lifo_table.sv
// top level: config register, sequencer and entry memory
//
// channel   direction  handshake                 payload
// command   in         start & !busy             operation, key, value_in
// result    out        done (one cycle)          status, value_out, entry_count
// config    in         psel&penable&pwrite       paddr, pwdata (max_entries)
//
// add and clear finish from idle and the next command is taken right after.
// find and remove scan one entry per cycle from the newest down through the
// memory read port; a find or remove on an empty table reports a miss
// without a scan, and remove then moves each newer entry down to close
// the gap.
// reset clears the count and the limit goes to 16; no memory clearing pass.
// the result cannot be stalled; busy holds off commands while a scan or gap close runs.
`default_nettype none

module bounded_keyed_lifo_table
  import blt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  operation,
  input  wire logic [31:0] key,
  input  wire logic [31:0] value_in,
  output logic             done,
  output logic      [1:0]  status,
  output logic      [31:0] value_out,
  output logic      [4:0]  entry_count,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [LIM_W-1:0] max_entries;
  mem_req_t         mem_req;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t           rdata;

  // config register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= MAX_ENTRIES_RESET;
    end else if (psel && penable && pwrite && (paddr == ADDR_MAX_ENTRIES)) begin
      max_entries <= pwdata[LIM_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_MAX_ENTRIES) ? 32'(max_entries) : '0;

  // sequencer
  blt_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .operation   (operation),
    .key         (key),
    .value_in    (value_in),
    .max_entries (max_entries),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .value_out   (value_out),
    .entry_count (entry_count),
    .mem_req     (mem_req),
    .rdata       (rdata)
  );

  // entry memory
  assign rdata = ram_rdata;

  blt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// self-checking testbench for the bounded keyed lifo table: directed and random traffic
`timescale 1ns / 1ps

module tb_top;
  import blt_pkg::*;

  // result of one table operation
  typedef struct {
    logic [1:0]  status;
    logic [31:0] value;
    logic [4:0]  count;
  } table_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  operation = OP_ADD;
  logic [31:0] key = '0;
  logic [31:0] value_in = '0;
  logic        done;
  logic [1:0]  status;
  logic [31:0] value_out;
  logic [4:0]  entry_count;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = ADDR_MAX_ENTRIES;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // shadow copy of the table
  logic [31:0]      table_key [CAPACITY];
  logic [31:0]      table_val [CAPACITY];
  logic             table_used [CAPACITY];
  int               table_count;
  logic [LIM_W-1:0] entry_limit;

  table_result_t pending_results[$];
  int            error_count = 0;
  int            sender_idle_pct = 0;
  logic [31:0]   key_pool [6];

  bounded_keyed_lifo_table DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .key         (key),
    .value_in    (value_in),
    .done        (done),
    .status      (status),
    .value_out   (value_out),
    .entry_count (entry_count),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk = ~clk;

  // apply one operation to the shadow table and return what the block should report
  function automatic table_result_t apply_op(logic [1:0] op, logic [31:0] k, logic [31:0] v);
    table_result_t r;
    int lim;
    int hit;
    r.status = ST_DONE;
    r.value  = '0;
    lim = (entry_limit > CAPACITY) ? CAPACITY : int'(entry_limit);
    case (op)
      OP_ADD: begin
        if (table_count < lim) begin
          for (int i = table_count; i > 0; i--) begin
            table_key[i]  = table_key[i-1];
            table_val[i]  = table_val[i-1];
            table_used[i] = table_used[i-1];
          end
          table_key[0]  = k;
          table_val[0]  = v;
          table_used[0] = 1'b1;
          table_count++;
          r.value = v;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_FIND, OP_REMOVE: begin
        hit = -1;
        for (int i = 0; i < CAPACITY; i++)
          if (hit < 0 && table_used[i] && table_key[i] == k) hit = i;
        if (hit < 0) begin
          r.status = ST_MISS;
        end else begin
          r.value = table_val[hit];
          if (op == OP_REMOVE) begin
            // close the gap behind the removed entry
            for (int i = hit; i + 1 < table_count; i++) begin
              table_key[i]  = table_key[i+1];
              table_val[i]  = table_val[i+1];
              table_used[i] = table_used[i+1];
            end
            table_count--;
            table_used[table_count] = 1'b0;
          end
        end
      end
      default: begin
        for (int i = 0; i < CAPACITY; i++) table_used[i] = 1'b0;
        table_count = 0;
      end
    endcase
    r.count = 5'(table_count);
    return r;
  endfunction

  function automatic void report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    error_count++;
    if (error_count <= 40)
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
  endfunction

  // model update on every accepted transfer, then compare any result
  always @(posedge clk) begin
    table_result_t want;
    if (rst) begin
      for (int i = 0; i < CAPACITY; i++) table_used[i] = 1'b0;
      table_count = 0;
      entry_limit = MAX_ENTRIES_RESET;
    end else begin
      if (psel && penable && pready && pwrite && paddr == ADDR_MAX_ENTRIES)
        entry_limit = pwdata[LIM_W-1:0];
      if (psel && penable && pready && !pwrite && paddr == ADDR_MAX_ENTRIES &&
          prdata[LIM_W-1:0] !== entry_limit)
        report_mismatch("max_entries readback", 32'(entry_limit), 32'(prdata[LIM_W-1:0]));
      if (start && !busy)
        pending_results.push_back(apply_op(operation, key, value_in));
      if (done) begin
        if (pending_results.size() == 0) begin
          error_count++;
          $display("%0t ns: unexpected result, expected none, actual status %0d value %h count %0d",
                   $time, status, value_out, entry_count);
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status)
            report_mismatch("status", 32'(want.status), 32'(status));
          if (value_out !== want.value)
            report_mismatch("value_out", want.value, value_out);
          if (entry_count !== want.count)
            report_mismatch("entry_count", 32'(want.count), 32'(entry_count));
        end
      end
    end
  end

  // issue one command and return in the step of its transfer
  task automatic send_op(logic [1:0] op, logic [31:0] k, logic [31:0] v);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    operation <= op;
    key       <= k;
    value_in  <= v;
    do @(posedge clk); while (busy);
  endtask

  // drop start and wait until every result is back and the block is free
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || busy);
    repeat (2) @(posedge clk);
  endtask

  // apb write followed by a readback of the limit register
  task automatic set_limit(logic [4:0] lim);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_MAX_ENTRIES;
    pwdata  <= {27'($urandom), lim};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // empty table, extreme keys and values, shadowing of duplicate keys
  task automatic test_edge_cases();
    send_op(OP_FIND, 32'h0, 32'hFFFF_FFFF);
    send_op(OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
    send_op(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_ADD, 32'h0, 32'h0);
    send_op(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_ADD, 32'h0, 32'h1234_5678);
    send_op(OP_FIND, 32'h0, 32'h0);
    send_op(OP_REMOVE, 32'h0, 32'hFFFF_FFFF);
    send_op(OP_FIND, 32'h0, 32'hA5A5_A5A5);
    send_op(OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
    send_op(OP_FIND, 32'hFFFF_FFFF, 32'h0);
    send_op(OP_CLEAR, 32'h0, 32'h0);
    wait_idle();
  endtask

  // zero limit, small limit, limit lowered below the count
  task automatic test_limit_cases();
    set_limit(5'd0);
    send_op(OP_ADD, 32'h5555_5555, 32'hAAAA_AAAA);
    wait_idle();
    set_limit(5'd2);
    send_op(OP_ADD, 32'h1, 32'h11);
    send_op(OP_ADD, 32'h2, 32'h22);
    send_op(OP_ADD, 32'h3, 32'h33);
    wait_idle();
    set_limit(5'd1);
    send_op(OP_ADD, 32'h4, 32'h44);
    send_op(OP_REMOVE, 32'h2, 32'h0);
    send_op(OP_ADD, 32'h5, 32'h55);
    send_op(OP_REMOVE, 32'h1, 32'h0);
    send_op(OP_ADD, 32'h6, 32'h66);
    send_op(OP_FIND, 32'h6, 32'h0);
    wait_idle();
    set_limit(5'd31);
  endtask

  // random operations over a small key pool, limit changed between chunks
  task automatic test_random_traffic(int n_items, int idle_pct);
    logic [1:0]  op;
    logic [31:0] k;
    logic [31:0] v;
    logic [4:0]  lim;
    int          r;
    sender_idle_pct = idle_pct;
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 6; i++) key_pool[i] = $urandom;
    for (int n = 0; n < n_items; n++) begin
      if (n % 60 == 0) begin
        case ((n / 60) % 8)
          0: lim = 5'd16;
          1: lim = 5'd31;
          2: lim = 5'd1;
          3: lim = 5'd8;
          4: lim = 5'd17;
          5: lim = 5'd0;
          6: lim = 5'($urandom_range(31));
          default: lim = 5'd3;
        endcase
        wait_idle();
        set_limit(lim);
      end
      r = $urandom_range(99);
      if (r < 45) op = OP_ADD;
      else if (r < 70) op = OP_FIND;
      else if (r < 97) op = OP_REMOVE;
      else op = OP_CLEAR;
      k = ($urandom_range(99) < 80) ? key_pool[$urandom_range(5)] : $urandom;
      r = $urandom_range(19);
      v = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
      send_op(op, k, v);
    end
    wait_idle();
  endtask

  // main sequence
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_edge_cases();
    test_limit_cases();
    test_random_traffic(410, 29);
    test_random_traffic(410, 58);
    test_random_traffic(410, 0);
    wait_idle();
    repeat (40) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(20_000_000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
